// File: rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// No dependencies; every other file of the block depends on this package.
package cau_pkg;

    // Fixed-point format of the operands and results
    localparam int FRAC_BITS = 8;
    localparam int DW        = 16;
    // Quotient and root bits produced by the iteration stages
    localparam int QB        = DW;
    // Product, divisor and remainder widths
    localparam int PW        = 2 * DW;
    localparam int YW        = PW + 1;
    localparam int RW        = YW + QB;
    localparam int SW        = PW + 4;
    localparam int SQW       = PW + 2;
    // Depth of the command queue between front and back
    localparam int QDEPTH    = 2;

    // Operation codes on the input word
    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_MOD = 3'd4;

    typedef logic signed [DW-1:0] t_word;

    // Classified operation, as the back end executes it
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_NONE,
        OP_DZ
    } t_op;

    typedef struct packed {
        t_op   op;
        t_word a_re;
        t_word a_im;
        t_word b_re;
        t_word b_im;
    } t_cmd;

    typedef struct packed {
        t_word res_re;
        t_word res_im;
        logic  overflow;
        logic  div_zero;
    } t_rsp;

endpackage

// File: rtl/cau_req_if.sv
// Request channel: operation code and two complex operands.
// Depends on cau_pkg.
interface cau_req_if;
    logic                 valid;
    logic                 ready;
    logic [2:0]           kind;
    logic signed [cau_pkg::DW-1:0] a_re;
    logic signed [cau_pkg::DW-1:0] a_im;
    logic signed [cau_pkg::DW-1:0] b_re;
    logic signed [cau_pkg::DW-1:0] b_im;

    modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: rtl/cau_rsp_if.sv
// Response channel: complex result and status flags.
// Depends on cau_pkg.
interface cau_rsp_if;
    logic                 valid;
    logic                 ready;
    logic signed [cau_pkg::DW-1:0] res_re;
    logic signed [cau_pkg::DW-1:0] res_im;
    logic                 overflow;
    logic                 div_zero;

    modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
    modport sink   (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

// File: rtl/cau_front.sv
// Front end: accepts request words, decodes the operation and flags a zero divisor.
// Depends on cau_pkg and cau_req_if.
module cau_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cau_req_if.sink       i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output cau_pkg::t_cmd o_cmd
);
    import cau_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    // Stage is free when empty or draining this cycle
    assign i_req.ready = !r_valid || i_ready;
    assign take        = i_req.valid && i_req.ready;

    // Decode the operation code
    always_comb begin
        n_cmd.a_re = i_req.a_re;
        n_cmd.a_im = i_req.a_im;
        n_cmd.b_re = i_req.b_re;
        n_cmd.b_im = i_req.b_im;
        unique case (i_req.kind)
            KIND_ADD: n_cmd.op = OP_ADD;
            KIND_SUB: n_cmd.op = OP_SUB;
            KIND_MUL: n_cmd.op = OP_MUL;
            KIND_DIV: begin
                n_cmd.op = (i_req.b_re == '0 && i_req.b_im == '0) ? OP_DZ : OP_DIV;
            end
            KIND_MOD: n_cmd.op = OP_MOD;
            default:  n_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

// File: rtl/cau_queue.sv
// Short command queue between front and back end.
// Depends on cau_pkg.
module cau_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  cau_pkg::t_cmd i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output cau_pkg::t_cmd o_pop_data
);
    import cau_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd          r_mem [QDEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CW'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// File: rtl/cau_back.sv
// Back end: multiplier stage, operand prep, 16 shared divide/square-root
// stages and a round/saturate output register. Depends on cau_pkg.
module cau_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cau_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output cau_pkg::t_rsp o_rsp
);
    import cau_pkg::*;

    localparam logic signed [SW-1:0] MAXV = SW'((1 << (DW - 1)) - 1);
    localparam logic signed [SW-1:0] MINV = -SW'(1 << (DW - 1));
    localparam logic signed [SW-1:0] RND  = SW'((1 << FRAC_BITS) >> 1);

    typedef struct packed {
        t_op                   op;
        t_word                 a_re;
        t_word                 a_im;
        t_word                 b_re;
        t_word                 b_im;
        logic signed [PW-1:0]  m0;
        logic signed [PW-1:0]  m1;
        logic signed [PW-1:0]  m2;
        logic signed [PW-1:0]  m3;
        logic signed [PW-1:0]  m4;
        logic signed [PW-1:0]  m5;
    } t_prod;

    typedef struct packed {
        t_op             op;
        t_word           pre_re;
        t_word           pre_im;
        logic            pre_ovf;
        logic            neg_r;
        logic            neg_i;
        logic            big_r;
        logic            big_i;
        logic [RW-1:0]   xr;
        logic [RW-1:0]   xi;
        logic [YW-1:0]   y;
        logic [QB-1:0]   qr;
        logic [QB-1:0]   qi;
        logic [SQW-1:0]  srem;
        logic [QB-1:0]   root;
    } t_pipe;

    typedef struct packed {
        t_word val;
        logic  ovf;
    } t_sat;

    logic  en;
    logic  r_vld_a;
    t_prod r_prod;
    t_prod n_prod;
    logic  r_vld [QB+1];
    t_pipe r_pipe [QB+1];
    t_pipe n_pipe [QB+1];
    logic  r_ovld;
    t_rsp  r_out;

    // Clamp a wide signed value to the word range
    function automatic t_sat sat(input logic signed [SW-1:0] v);
        t_sat s;
        if (v > MAXV) begin
            s.val = t_word'(MAXV);
            s.ovf = 1'b1;
        end else if (v < MINV) begin
            s.val = t_word'(MINV);
            s.ovf = 1'b1;
        end else begin
            s.val = t_word'(v);
            s.ovf = 1'b0;
        end
        return s;
    endfunction

    // Shift right by FRAC_BITS, round to nearest, ties away from zero
    function automatic logic signed [SW-1:0] shr_rnd(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + RND) >>> FRAC_BITS;
        return (v < 0) ? -mag : mag;
    endfunction

    // Sums, rounding of products and divide/modulus setup
    function automatic t_pipe prep(input t_prod p);
        t_pipe                q;
        t_sat                 sr;
        t_sat                 si;
        logic signed [SW-1:0] vr;
        logic signed [SW-1:0] vi;
        logic [PW-1:0]        magr;
        logic [PW-1:0]        magi;
        logic [PW-1:0]        d;
        q      = '0;
        q.op   = p.op;
        vr     = '0;
        vi     = '0;
        case (p.op)
            OP_ADD: begin
                vr = SW'(p.a_re) + SW'(p.b_re);
                vi = SW'(p.a_im) + SW'(p.b_im);
            end
            OP_SUB: begin
                vr = SW'(p.a_re) - SW'(p.b_re);
                vi = SW'(p.a_im) - SW'(p.b_im);
            end
            OP_MUL: begin
                vr = shr_rnd(SW'(p.m0) - SW'(p.m1));
                vi = shr_rnd(SW'(p.m2) + SW'(p.m3));
            end
            OP_DIV: begin
                vr = SW'(p.m0) + SW'(p.m1);
                vi = SW'(p.m3) - SW'(p.m2);
            end
            default: begin
                vr = '0;
                vi = '0;
            end
        endcase
        sr        = sat(vr);
        si        = sat(vi);
        q.pre_re  = sr.val;
        q.pre_im  = si.val;
        q.pre_ovf = sr.ovf || si.ovf;
        // Divide: quotient = floor((2|N|*2^F + D) / 2D)
        magr    = PW'((vr < 0) ? -vr : vr);
        magi    = PW'((vi < 0) ? -vi : vi);
        d       = PW'(p.m4) + PW'(p.m5);
        q.neg_r = (vr < 0);
        q.neg_i = (vi < 0);
        q.y     = {d, 1'b0};
        q.xr    = (RW'(magr) << (FRAC_BITS + 1)) + RW'(d);
        q.xi    = (RW'(magi) << (FRAC_BITS + 1)) + RW'(d);
        q.big_r = (q.xr >= (RW'(q.y) << QB));
        q.big_i = (q.xi >= (RW'(q.y) << QB));
        // Modulus: radicand a_re^2 + a_im^2, summed wide enough for 2^31
        q.srem  = SQW'(p.m0) + SQW'(p.m1);
        return q;
    endfunction

    // One quotient bit for each lane and one root bit
    function automatic t_pipe step(input t_pipe p, input int i);
        t_pipe          q;
        logic [RW-1:0]  ty;
        logic [SQW-1:0] t;
        q  = p;
        ty = RW'(p.y) << i;
        if (p.xr >= ty) begin
            q.xr    = p.xr - ty;
            q.qr[i] = 1'b1;
        end
        if (p.xi >= ty) begin
            q.xi    = p.xi - ty;
            q.qi[i] = 1'b1;
        end
        t = (SQW'(p.root) << (i + 1)) + (SQW'(1) << (2 * i));
        if (p.srem >= t) begin
            q.srem    = p.srem - t;
            q.root[i] = 1'b1;
        end
        return q;
    endfunction

    // Signed saturation of a quotient magnitude
    function automatic t_sat div_lane(input logic big, input logic neg,
                                      input logic [QB-1:0] qv);
        t_sat s;
        if (neg) begin
            if (big || ({1'b0, qv} > {1'b0, QB'(1 << (DW - 1))})) begin
                s.val = t_word'(MINV);
                s.ovf = 1'b1;
            end else begin
                s.val = t_word'(-qv);
                s.ovf = 1'b0;
            end
        end else begin
            if (big || (qv > QB'(MAXV))) begin
                s.val = t_word'(MAXV);
                s.ovf = 1'b1;
            end else begin
                s.val = t_word'(qv);
                s.ovf = 1'b0;
            end
        end
        return s;
    endfunction

    // Final rounding and packing of the result word
    function automatic t_rsp fin(input t_pipe p);
        t_rsp        r;
        t_sat        sr;
        t_sat        si;
        logic [QB:0] rt;
        r  = '0;
        sr = div_lane(p.big_r, p.neg_r, p.qr);
        si = div_lane(p.big_i, p.neg_i, p.qi);
        rt = {1'b0, p.root} + ((p.srem > SQW'(p.root)) ? (QB+1)'(1) : '0);
        case (p.op)
            OP_DIV: begin
                r.res_re   = sr.val;
                r.res_im   = si.val;
                r.overflow = sr.ovf || si.ovf;
            end
            OP_MOD: begin
                if (rt > (QB+1)'(MAXV)) begin
                    r.res_re   = t_word'(MAXV);
                    r.overflow = 1'b1;
                end else begin
                    r.res_re = t_word'(rt);
                end
            end
            OP_DZ: begin
                r.div_zero = 1'b1;
            end
            default: begin
                r.res_re   = p.pre_re;
                r.res_im   = p.pre_im;
                r.overflow = p.pre_ovf;
            end
        endcase
        return r;
    endfunction

    // Whole pipeline advances unless the output word is stalled
    assign en      = !r_ovld || i_ready;
    assign o_ready = en;

    // Multiplier operands; modulus squares a
    always_comb begin
        n_prod.op   = i_cmd.op;
        n_prod.a_re = i_cmd.a_re;
        n_prod.a_im = i_cmd.a_im;
        n_prod.b_re = i_cmd.b_re;
        n_prod.b_im = i_cmd.b_im;
        n_prod.m0   = PW'(i_cmd.a_re) * PW'((i_cmd.op == OP_MOD) ? i_cmd.a_re : i_cmd.b_re);
        n_prod.m1   = PW'(i_cmd.a_im) * PW'((i_cmd.op == OP_MOD) ? i_cmd.a_im : i_cmd.b_im);
        n_prod.m2   = PW'(i_cmd.a_re) * PW'(i_cmd.b_im);
        n_prod.m3   = PW'(i_cmd.a_im) * PW'(i_cmd.b_re);
        n_prod.m4   = PW'(i_cmd.b_re) * PW'(i_cmd.b_re);
        n_prod.m5   = PW'(i_cmd.b_im) * PW'(i_cmd.b_im);
    end

    // Next value of every iteration stage
    always_comb begin
        n_pipe[0] = prep(r_prod);
        for (int k = 1; k <= QB; k++) begin
            n_pipe[k] = step(r_pipe[k-1], QB - k);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_ovld  <= 1'b0;
            for (int k = 0; k <= QB; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld_a  <= i_valid;
            r_vld[0] <= r_vld_a;
            for (int k = 1; k <= QB; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ovld <= r_vld[QB];
        end
    end

    // Data path registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= n_prod;
            for (int k = 0; k <= QB; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
            r_out <= fin(r_pipe[QB]);
        end
    end

    assign o_valid = r_ovld;
    assign o_rsp   = r_out;

endmodule

// File: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide and modulus on
// signed Q8.8 complex operands, with rounding and saturation to 16 bits.
// One request word is accepted every clock cycle while the response side
// takes words; a word passes through the front register, the queue, the
// multiplier, setup, the one-bit-per-stage divide and square-root pipeline
// (16 stages) and the output register before its result is offered. A stall
// on the response side holds the back end; the two-entry queue and front
// register keep accepting until they fill. Depends on cau_pkg, the channel
// interfaces, cau_front, cau_queue and cau_back.
module complex_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_req_if.sink   i_req,
    cau_rsp_if.source o_rsp
);
    import cau_pkg::*;

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;
    t_rsp rsp;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cmd   (f_cmd)
    );

    cau_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_cmd)
    );

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cmd   (q_cmd),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_rsp   (rsp)
    );

    assign o_rsp.res_re   = rsp.res_re;
    assign o_rsp.res_im   = rsp.res_im;
    assign o_rsp.overflow = rsp.overflow;
    assign o_rsp.div_zero = rsp.div_zero;

endmodule

// File: rtl/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit.
module cau_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic signed [cau_pkg::DW-1:0] i_res_re,
    input logic signed [cau_pkg::DW-1:0] i_res_im,
    input logic                  i_overflow,
    input logic                  i_div_zero
);
    import cau_pkg::*;

    // A stalled result word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_res_re) && $stable(i_res_im))
        else $error("result word changed while stalled");

    // Zero divisor gives a clean zero result
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_div_zero |-> i_res_re == '0 && i_res_im == '0 && !i_overflow)
        else $error("divide-by-zero word not zero");

    // Nothing is offered right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word offered after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_res_re    (o_rsp.res_re),
    .i_res_im    (o_rsp.res_im),
    .i_overflow  (o_rsp.overflow),
    .i_div_zero  (o_rsp.div_zero)
);
